// ----- sv/assert_macros.svh -----
// Assertion helpers for the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a condition at the same edge as the trigger.
`define ASSERT_SAME(label, clk, rst_n, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
        else $error(msg);

// Check a condition at the edge after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

// ----- sv/sucd_pkg.sv -----
`timescale 1ns / 1ps

package sucd_pkg;

    localparam int MAX_LOG_COEFS_DEF = 10;
    localparam int IDX_W             = 11;
    localparam int BYTE_CNT_W        = 12;
    localparam int MAG_W             = 11;

    localparam logic [3:0]            LOG_COEF_RESET = 4'd9;
    localparam logic [BYTE_CNT_W-1:0] BYTE_COUNT_MAX = 12'd4095;
    localparam logic [11:0]           MAG_LIMIT      = 12'd2047;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MAG_HIGH = 3'd1;
    localparam logic [2:0] ST_NEG_ZERO = 3'd2;
    localparam logic [2:0] ST_PADDING  = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic                     coef_valid;
        logic signed [11:0]       coefficient;
        logic                     frame_end;
        logic [2:0]               status;
        logic [BYTE_CNT_W-1:0]    bytes_used;
    } coef_item_t;

    typedef struct packed {
        logic [6:0]            leftover_bits;
        logic [2:0]            leftover_count;
        logic                  in_unary_part;
        logic                  sign_bit;
        logic [MAG_W-1:0]      magnitude;
        logic [IDX_W-1:0]      coef_index;
        logic [BYTE_CNT_W-1:0] byte_count;
        logic                  skipping_to_end;
    } dec_state_t;

endpackage

// ----- sv/sucd_stream_if.sv -----
`timescale 1ns / 1ps

interface sucd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/sucd_step.sv -----
`timescale 1ns / 1ps

module sucd_step
    import sucd_pkg::*;
#(
    parameter int MAX_LOG_COEFS = MAX_LOG_COEFS_DEF
) (
    input  dec_state_t st,
    input  byte_item_t item,
    input  logic [3:0] log_coef_count,
    output dec_state_t st_next,
    output logic       produce,
    output coef_item_t res
);
    localparam int CNT_W = MAX_LOG_COEFS + 1;
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    logic [14:0]           pool;
    logic [7:0]            hdr;
    logic [3:0]            scan_len;
    logic [7:0]            scan;
    logic                  found;
    logic [2:0]            first_pos;
    logic [3:0]            zeros;
    logic [MAG_W-1:0]      mag_base;
    logic                  sgn;
    logic [11:0]           mag_sum;
    logic                  overflow;
    logic [6:0]            rest;
    logic [3:0]            lg;
    logic [CNT_W-1:0]      count;
    logic [IDX_W-1:0]      idx_inc;
    logic                  complete;
    logic [BYTE_CNT_W-1:0] bc_next;
    logic signed [11:0]    value;
    dec_state_t            cleared;

    always_comb
    begin
        pool     = {st.leftover_bits, item.data_byte};
        hdr      = 8'(pool >> st.leftover_count);
        scan_len = st.in_unary_part ? 4'd8 : {1'b0, st.leftover_count};
        scan     = item.data_byte & 8'((9'd1 << scan_len) - 9'd1);
        found    = |scan;
        first_pos = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (scan[i])
            begin
                first_pos = 3'(i);
            end
        end
        zeros    = found ? 4'(scan_len - 4'd1 - {1'b0, first_pos}) : scan_len;
        mag_base = st.in_unary_part ? st.magnitude : {4'd0, hdr[6:0]};
        sgn      = st.in_unary_part ? st.sign_bit : hdr[7];
        mag_sum  = {1'b0, mag_base} + {1'b0, zeros, 7'd0};
        overflow = mag_sum > MAG_LIMIT;
        rest     = 7'(item.data_byte & 8'((9'd1 << first_pos) - 9'd1));
        value    = sgn ? 12'(-{1'b0, mag_sum[MAG_W-1:0]}) : {1'b0, mag_sum[MAG_W-1:0]};

        lg       = (log_coef_count > 4'(MAX_LOG_COEFS)) ? 4'(MAX_LOG_COEFS) : log_coef_count;
        count    = {{(CNT_W-1){1'b0}}, 1'b1} << lg;
        idx_inc  = st.coef_index + 1'b1;
        complete = CMP_W'(idx_inc) >= CMP_W'(count);
        bc_next  = (st.byte_count == BYTE_COUNT_MAX) ? st.byte_count
                                                     : st.byte_count + 1'b1;

        cleared = '0;
        cleared.skipping_to_end = !item.last_byte;

        st_next            = st;
        st_next.byte_count = bc_next;
        produce            = 1'b0;
        res                = '0;

        if (st.skipping_to_end)
        begin
            // Drop bytes up to the end of the frame.
            st_next = st;
            if (item.last_byte)
            begin
                st_next.skipping_to_end = 1'b0;
            end
        end
        else if (overflow)
        begin
            produce       = 1'b1;
            res.frame_end = 1'b1;
            res.status    = ST_MAG_HIGH;
            st_next       = cleared;
        end
        else if (!found)
        begin
            // No terminating one in this byte; hold the partial magnitude.
            st_next.leftover_bits  = '0;
            st_next.leftover_count = '0;
            st_next.in_unary_part  = 1'b1;
            st_next.sign_bit       = sgn;
            st_next.magnitude      = mag_sum[MAG_W-1:0];
            if (item.last_byte)
            begin
                produce       = 1'b1;
                res.frame_end = 1'b1;
                res.status    = ST_TRUNC;
                st_next       = cleared;
            end
        end
        else if (sgn && mag_sum == 12'd0)
        begin
            produce       = 1'b1;
            res.frame_end = 1'b1;
            res.status    = ST_NEG_ZERO;
            st_next       = cleared;
        end
        else
        begin
            produce                = 1'b1;
            res.coef_valid         = 1'b1;
            res.coefficient        = value;
            st_next.in_unary_part  = 1'b0;
            st_next.sign_bit       = sgn;
            st_next.magnitude      = mag_sum[MAG_W-1:0];
            st_next.leftover_bits  = rest;
            st_next.leftover_count = first_pos;
            st_next.coef_index     = idx_inc;
            if (complete)
            begin
                res.frame_end = 1'b1;
                if (rest != 7'd0)
                begin
                    res.status = ST_PADDING;
                end
                else
                begin
                    res.status     = ST_OK;
                    res.bytes_used = bc_next;
                end
                st_next = cleared;
            end
            else if (item.last_byte)
            begin
                res.frame_end = 1'b1;
                res.status    = ST_TRUNC;
                st_next       = cleared;
            end
        end
    end

endmodule

// ----- sv/signed_unary_coef_decoder.sv -----
`timescale 1ns / 1ps
// Compressed coefficient decoder.
// bytes: one compressed byte per request (data_byte, last_byte), MSB first.
// coefs: zero or one result per byte: a decoded coefficient, a frame end
//   with status, and on a clean finish the number of bytes used.
// cfg:   write log_coef_count (log2 of coefficients per frame); always ready.
//   Write only while no byte is in flight.
// A byte waits in the input register; its result goes to the result register.
// Throughput: one byte per cycle while results drain; each byte is decoded in
//   a single pass of shift, first-one search and magnitude add between the
//   input register and the result register.
// After a frame ends early (error or completion), bytes up to and including
//   the next last_byte are taken and dropped without a result.
// Reset clears all frame state, empties both registers and sets
//   log_coef_count to 9.
// When coefs stalls, the pending result holds; the input register still
//   drains bytes that make no result and accepts a new byte as soon as its
//   current byte can retire.

module signed_unary_coef_decoder
    import sucd_pkg::*;
#(
    parameter int MAX_LOG_COEFS = MAX_LOG_COEFS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    sucd_stream_if.sink   bytes,
    sucd_stream_if.source coefs,
    sucd_stream_if.sink   cfg
);
    `include "assert_macros.svh"

    logic [3:0] log_coef_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    byte_item_t in_item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    coef_item_t out_item_reg;
    dec_state_t st_reg;
    dec_state_t st_next;
    logic       produce;
    coef_item_t res;
    logic       advance;
    logic       in_take;

    sucd_step #(
        .MAX_LOG_COEFS(MAX_LOG_COEFS)
    ) u_step (
        .st            (st_reg),
        .item          (in_item_reg),
        .log_coef_count(log_coef_reg),
        .st_next       (st_next),
        .produce       (produce),
        .res           (res)
    );

    // Retire the held byte unless its result would overwrite a stalled one.
    assign advance   = in_valid_reg && (!produce || !out_valid_reg || coefs.ready);
    assign in_take   = bytes.valid && bytes.ready;
    assign bytes.ready = !in_valid_reg || advance;
    assign cfg.ready   = 1'b1;

    assign coefs.valid   = out_valid_reg;
    assign coefs.payload = out_item_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (coefs.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_coef_reg  <= LOG_COEF_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                log_coef_reg <= cfg.payload;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= bytes.payload;
        end
        if (advance && produce)
        begin
            out_item_reg <= res;
        end
    end

    `ASSERT_ALWAYS(a_leftover_fits, clk, rst_n,
        (st_reg.leftover_bits >> st_reg.leftover_count) == 7'd0,
        "leftover bits exceed leftover count")
    `ASSERT_SAME(a_unary_no_leftover, clk, rst_n, st_reg.in_unary_part,
        st_reg.leftover_count == 3'd0, "leftover bits held inside unary part")
    `ASSERT_SAME(a_error_ends_frame, clk, rst_n,
        out_valid_reg && out_item_reg.status != ST_OK,
        out_item_reg.frame_end, "error status without frame end")
    `ASSERT_NEXT(a_end_clears_frame, clk, rst_n, advance && produce && res.frame_end,
        st_reg.coef_index == '0 && st_reg.byte_count == '0,
        "frame state not cleared after frame end")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import sucd_pkg::*;

    localparam int ITEM_GOAL     = 1150;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;

    typedef enum int {
        FR_CLEAN,
        FR_TRAILING,
        FR_TRUNC,
        FR_OVERFLOW,
        FR_NEG_ZERO,
        FR_PADDING,
        FR_BITFLIP,
        FR_NOISE
    } frame_kind_t;

    logic clk = 1'b0;
    logic rst_n;

    sucd_stream_if #(.payload_t(byte_item_t)) bytes_if ();
    sucd_stream_if #(.payload_t(coef_item_t)) coefs_if ();
    sucd_stream_if #(.payload_t(logic [3:0])) cfg_if ();

    signed_unary_coef_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes_if),
        .coefs (coefs_if),
        .cfg   (cfg_if)
    );

    // Decoder state as the testbench sees it
    logic [3:0]  dec_log       = LOG_COEF_RESET;
    logic [6:0]  dec_left_bits = '0;
    logic [2:0]  dec_left_cnt  = '0;
    bit          dec_unary     = 1'b0;
    bit          dec_sign      = 1'b0;
    int          dec_mag       = 0;
    logic [10:0] dec_idx       = '0;
    logic [11:0] dec_bytes     = '0;
    bit          dec_skip      = 1'b0;

    coef_item_t expected_coefs[$];
    bit         frame_bits[$];
    int         taken_bytes   = 0;
    int         mismatches    = 0;
    int         quiet_cycles  = 0;
    int         hold_request  = 0;
    bit         feed_gaps     = 1'b1;
    bit         drain_gaps    = 1'b1;

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void close_frame(input logic last);
        dec_left_bits = '0;
        dec_left_cnt  = '0;
        dec_unary     = 1'b0;
        dec_sign      = 1'b0;
        dec_mag       = 0;
        dec_idx       = '0;
        dec_bytes     = '0;
        dec_skip      = !last;
    endfunction

    // Decode one byte; returns 1 when the byte produces a result
    function automatic bit decode_byte(input logic [7:0] d, input logic last,
                                       output coef_item_t r);
        int          lg;
        int          count;
        int          len;
        logic [14:0] pool;
        logic [14:0] rest;
        logic [7:0]  hdr;
        logic [11:0] mag12;
        bit          closed;
        bit          overflow;
        bit          emit;
        r        = '0;
        closed   = 1'b0;
        overflow = 1'b0;
        emit     = 1'b0;
        taken_bytes++;
        if (dec_skip)
        begin
            if (last)
                dec_skip = 1'b0;
            return 1'b0;
        end
        lg    = (dec_log > MAX_LOG_COEFS_DEF) ? MAX_LOG_COEFS_DEF : int'(dec_log);
        count = 1 << lg;
        if (dec_bytes < BYTE_COUNT_MAX)
            dec_bytes++;
        pool = {dec_left_bits, d};
        len  = dec_left_cnt + 8;
        if (!dec_unary)
        begin
            hdr       = 8'(pool >> (len - 8));
            dec_sign  = hdr[7];
            dec_mag   = int'(hdr[6:0]);
            len       = len - 8;
            dec_unary = 1'b1;
        end
        while (len > 0 && !closed && !overflow)
        begin
            len--;
            if (pool[len])
                closed = 1'b1;
            else
            begin
                dec_mag += 128;
                if (dec_mag > MAG_LIMIT)
                    overflow = 1'b1;
            end
        end
        if (overflow)
        begin
            r.frame_end = 1'b1;
            r.status    = ST_MAG_HIGH;
            emit        = 1'b1;
            close_frame(last);
        end
        else if (!closed)
        begin
            dec_left_bits = '0;
            dec_left_cnt  = '0;
            if (last)
            begin
                r.frame_end = 1'b1;
                r.status    = ST_TRUNC;
                emit        = 1'b1;
                close_frame(last);
            end
        end
        else if (dec_sign && dec_mag == 0)
        begin
            r.frame_end = 1'b1;
            r.status    = ST_NEG_ZERO;
            emit        = 1'b1;
            close_frame(last);
        end
        else
        begin
            emit          = 1'b1;
            mag12         = 12'(dec_mag);
            r.coef_valid  = 1'b1;
            r.coefficient = dec_sign ? -mag12 : mag12;
            rest          = pool & ((15'd1 << len) - 15'd1);
            dec_unary     = 1'b0;
            dec_left_bits = rest[6:0];
            dec_left_cnt  = 3'(len);
            dec_idx       = dec_idx + 11'd1;
            if (int'(dec_idx) >= count)
            begin
                r.frame_end = 1'b1;
                if (rest != 0)
                    r.status = ST_PADDING;
                else
                begin
                    r.status     = ST_OK;
                    r.bytes_used = dec_bytes;
                end
                close_frame(last);
            end
            else if (last)
            begin
                r.frame_end = 1'b1;
                r.status    = ST_TRUNC;
                close_frame(last);
            end
        end
        return emit;
    endfunction

    // Check results and predict at every accepted request
    always @(posedge clk)
    begin : monitor
        coef_item_t want;
        coef_item_t got;
        coef_item_t pred;
        if (rst_n)
        begin
            if (coefs_if.valid && coefs_if.ready)
            begin
                got = coefs_if.payload;
                if (expected_coefs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: extra result v=%0b c=%0d e=%0b s=%0d u=%0d",
                                 $realtime, got.coef_valid, got.coefficient,
                                 got.frame_end, got.status, got.bytes_used);
                end
                else
                begin
                    want = expected_coefs.pop_front();
                    if (got.coef_valid !== want.coef_valid ||
                        got.coefficient !== want.coefficient ||
                        got.frame_end !== want.frame_end ||
                        got.status !== want.status ||
                        got.bytes_used !== want.bytes_used)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("%0t: mismatch exp v=%0b c=%0d e=%0b s=%0d u=%0d",
                                     $realtime, want.coef_valid, want.coefficient,
                                     want.frame_end, want.status, want.bytes_used);
                            $display("%0t:          got v=%0b c=%0d e=%0b s=%0d u=%0d",
                                     $realtime, got.coef_valid, got.coefficient,
                                     got.frame_end, got.status, got.bytes_used);
                        end
                    end
                end
            end
            if (bytes_if.valid && bytes_if.ready)
            begin
                if (decode_byte(bytes_if.payload.data_byte, bytes_if.payload.last_byte, pred))
                    expected_coefs.push_back(pred);
            end
            if ((bytes_if.valid && bytes_if.ready) || (coefs_if.valid && coefs_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus a long hold when one is requested
    initial
    begin : result_sink
        int stall;
        coefs_if.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = drain_gaps ? $urandom_range(0, 13) : 0;
            if (hold_request > 0)
            begin
                stall        = hold_request;
                hold_request = 0;
            end
            if (stall > 0)
            begin
                coefs_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            coefs_if.ready <= 1'b1;
            do @(posedge clk); while (!(coefs_if.valid && coefs_if.ready));
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic last);
        int gap;
        gap = feed_gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            bytes_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bytes_if.valid   <= 1'b1;
        bytes_if.payload <= {d, last};
        do @(posedge clk); while (!(bytes_if.valid && bytes_if.ready));
    endtask

    // Stop feeding and wait until every predicted result has come back
    task automatic settle();
        bytes_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_coefs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_log_count(input logic [3:0] value);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= value;
        do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
        dec_log = value;
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void put_coef(input bit sgn, input int mag, input int zeros);
        frame_bits.push_back(sgn);
        for (int k = 6; k >= 0; k--)
            frame_bits.push_back(mag[k]);
        repeat (zeros) frame_bits.push_back(1'b0);
        frame_bits.push_back(1'b1);
    endfunction

    task automatic send_frame(input int n_coefs, input frame_kind_t kind);
        int         bad_at;
        int         pad;
        int         nbytes;
        int         cut;
        int         mag;
        int         flip;
        int         pick;
        bit         sgn;
        logic [7:0] b;
        frame_bits.delete();
        if (kind == FR_NOISE)
        begin
            cut = $urandom_range(1, 12);
            for (int k = 0; k < cut; k++)
                push_byte(8'($urandom), (k == cut - 1) || ($urandom_range(0, 3) == 0));
        end
        else
        begin
            bad_at = -1;
            if (kind == FR_OVERFLOW || kind == FR_NEG_ZERO)
                bad_at = $urandom_range(0, n_coefs - 1);
            for (int i = 0; i < n_coefs; i++)
            begin
                if (i == bad_at && kind == FR_OVERFLOW)
                    put_coef(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                             $urandom_range(16, 18));
                else if (i == bad_at)
                    put_coef(1'b1, 0, 0);
                else
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        mag = $urandom_range(0, 127);
                    else if (pick < 9)
                        mag = $urandom_range(0, 700);
                    else
                        mag = $urandom_range(0, 2047);
                    sgn = (mag != 0) && ($urandom_range(0, 1) == 1);
                    put_coef(sgn, mag, mag >> 7);
                end
            end
            pad = (8 - frame_bits.size() % 8) % 8;
            for (int k = 0; k < pad; k++)
                frame_bits.push_back(kind == FR_PADDING ? 1'($urandom_range(0, 1)) : 1'b0);
            if (kind == FR_PADDING && pad > 0)
                frame_bits[frame_bits.size() - 1] = 1'b1;
            if (kind == FR_BITFLIP)
            begin
                flip = $urandom_range(0, frame_bits.size() - 1);
                frame_bits[flip] = !frame_bits[flip];
            end
            nbytes = frame_bits.size() / 8;
            cut = nbytes;
            if (kind == FR_TRUNC)
                cut = $urandom_range(1, (nbytes - 1 < 40) ? nbytes - 1 : 40);
            for (int k = 0; k < cut; k++)
            begin
                for (int j = 0; j < 8; j++)
                    b[7 - j] = frame_bits[8 * k + j];
                push_byte(b, kind != FR_TRAILING && k == cut - 1);
            end
            // frame finished on a byte without last: the tail gets dropped
            if (kind == FR_TRAILING)
            begin
                repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
                push_byte(8'($urandom), 1'b1);
            end
        end
    endtask

    task automatic test_coef_extremes();
        write_log_count(4'd0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b1);
        push_byte(8'h81, 1'b0);
        push_byte(8'h80, 1'b1);
    endtask

    task automatic test_decode_errors();
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hC0, 1'b1);
    endtask

    task automatic test_skip_to_last();
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h12, 1'b1);
        settle();
    endtask

    task automatic test_truncation();
        write_log_count(4'd1);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b1);
        settle();
    endtask

    task automatic test_oversized_count();
        write_log_count(4'd15);
        push_byte(8'h55, 1'b0);
        push_byte(8'hFF, 1'b1);
        settle();
    endtask

    // Shrink the count while a frame is open; the next coefficient passes it
    task automatic test_midframe_config();
        write_log_count(4'd3);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h40, 1'b0);
        settle();
        write_log_count(4'd1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b1);
        settle();
    endtask

    task automatic test_backpressure();
        feed_gaps = 1'b0;
        write_log_count(4'd1);
        hold_request = 150;
        repeat (12) send_frame(2, FR_CLEAN);
        settle();
        feed_gaps = 1'b1;
    endtask

    task automatic test_random_frames();
        int          lg;
        int          r;
        frame_kind_t kind;
        while (taken_bytes < ITEM_GOAL)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                settle();
                r = $urandom_range(0, 9);
                if (r < 6)
                    write_log_count(4'($urandom_range(0, 3)));
                else if (r < 8)
                    write_log_count(4'($urandom_range(4, 6)));
                else
                    write_log_count(4'($urandom_range(7, 15)));
            end
            feed_gaps  = $urandom_range(0, 4) != 0;
            drain_gaps = $urandom_range(0, 4) != 0;
            lg = (dec_log > MAX_LOG_COEFS_DEF) ? MAX_LOG_COEFS_DEF : int'(dec_log);
            r  = $urandom_range(0, 99);
            // large frames only get short truncated or noisy traffic
            if (lg >= 7)
                kind = (r < 70) ? FR_TRUNC : FR_NOISE;
            else
                kind = (r < 50) ? FR_CLEAN :
                       (r < 60) ? FR_TRAILING :
                       (r < 68) ? FR_TRUNC :
                       (r < 74) ? FR_OVERFLOW :
                       (r < 80) ? FR_NEG_ZERO :
                       (r < 87) ? FR_PADDING :
                       (r < 94) ? FR_BITFLIP : FR_NOISE;
            send_frame(1 << lg, kind);
        end
        feed_gaps  = 1'b1;
        drain_gaps = 1'b1;
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        bytes_if.valid   <= 1'b0;
        bytes_if.payload <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.payload   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_coef_extremes();
        test_decode_errors();
        test_skip_to_last();
        test_truncation();
        test_oversized_count();
        test_midframe_config();
        test_backpressure();
        test_random_frames();
        settle();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/sucd_pkg.sv
sv/sucd_stream_if.sv
sv/sucd_step.sv
sv/signed_unary_coef_decoder.sv
sim/tb.sv
